[design/pgew_pkg.sv]
// shared constants and types of the pixel grid edge weight block
package pgew_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int DIM_W      = 12;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int IDX_W      = 22;
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int WEIGHT_W   = 17;
	localparam int FRAC_W     = 8;
	localparam int SUM_W      = 2 * CHAN_W + 2;
	localparam int RAD_W      = 2 * WEIGHT_W;
	localparam int ITER_W     = $clog2(WEIGHT_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic MODE_GRAY = 1'b0;
	localparam logic MODE_RGB  = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_ROOT,
		S_DONE
	} pgew_state_t;

endpackage

[design/pgew_sqrt.sv]
// bit-serial integer square root, one result bit per cycle
module pgew_sqrt import pgew_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RAD_W-1:0]    radicand,
	output logic                done,
	output logic [WEIGHT_W-1:0] root
);

	logic [RAD_W-1:0]    rad_q;
	logic [WEIGHT_W+1:0] rem_q;
	logic [WEIGHT_W-1:0] root_q;
	logic [ITER_W-1:0]   cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [WEIGHT_W+3:0] rem_sh;
	logic [WEIGHT_W+3:0] trial;
	logic [WEIGHT_W+3:0] rem_nx;
	logic                fits;

	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		fits   = rem_sh >= trial;
		rem_nx = fits ? rem_sh - trial : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(WEIGHT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_nx[WEIGHT_W+1:0];
			root_q <= {root_q[WEIGHT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[design/pixel_grid_edge_weights.sv]
// top level: raster pixel stream in, four-connected edge words out
//
// pixels enter on the in channel (valid/ready) in raster order; for each pixel
// the block sends the edge from its left neighbour, then the edge from its
// upper neighbour, on the out channel (valid/ready); last_edge marks the final
// word of a pixel; the first pixel of a frame sends nothing
// the previous row sits in a one-port row memory, read and rewritten at the
// column of the accepted pixel in the cycle of acceptance
// one pixel is worked at a time; each edge weight waits on the bit-serial
// square root in rgb mode but not in grayscale mode, and a pixel without
// edges leaves the block idle, ready for the next pixel
// the output register lets the block take the next pixel while the last word
// waits; a stalled receiver holds the block once the next word is finished
// reset clears counters and registers and restores width 2048, height 2048
// and rgb mode; the row memory needs no clearing since a row is always written
// before it is read; writing width or height restarts the frame
module pixel_grid_edge_weights import pgew_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CHAN_W-1:0]     red_or_gray,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      source_index,
	output logic [IDX_W-1:0]      dest_index,
	output logic [WEIGHT_W-1:0]   edge_weight,
	output logic                  last_edge,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pgew_state_t state_q, state_nx;

	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic                mode_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [IDX_W-1:0]    idx_q;

	logic [PIX_W-1:0]    row_mem [MAX_WIDTH];
	logic [PIX_W-1:0]    row_rd_q;
	logic [PIX_W-1:0]    cur_q;
	logic [PIX_W-1:0]    left_q;
	logic [PIX_W-1:0]    prev_q;
	logic [IDX_W-1:0]    dest_q;
	logic                has_up_q;
	logic                edge_up_q;
	logic [WEIGHT_W-1:0] wt_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    src_out_q;
	logic [IDX_W-1:0]    dest_out_q;
	logic [WEIGHT_W-1:0] wt_out_q;
	logic                last_out_q;

	logic [DIM_W-1:0]    w_eff;
	logic [DIM_W-1:0]    h_eff;
	logic                accept;
	logic                col_last;
	logic                row_last;
	logic [PIX_W-1:0]    pix;
	logic [PIX_W-1:0]    nbr;
	logic [CHAN_W-1:0]   dr, dg, db;
	logic [2*CHAN_W-1:0] sr, sg, sb;
	logic [SUM_W-1:0]    sum;
	logic [RAD_W-1:0]    radicand;
	logic [WEIGHT_W-1:0] gray_wt;
	logic [WEIGHT_W-1:0] root;
	logic                load;
	logic                more;
	logic                sq_start;
	logic                sq_done;

	function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign pix      = {blue, green, red_or_gray};
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign col_last = (DIM_W'(col_q) + DIM_W'(1)) == w_eff;
	assign row_last = (DIM_W'(row_q) + DIM_W'(1)) == h_eff;

	// configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
			mode_q   <= MODE_RGB;
			col_q    <= '0;
			row_q    <= '0;
			idx_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
					idx_q   <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
					idx_q    <= '0;
				end
				REG_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q <= '0;
					idx_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
					idx_q <= idx_q + IDX_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// row memory, read before write at the same column
	always_ff @(posedge clk) begin
		if (accept) begin
			row_rd_q       <= row_mem[col_q];
			row_mem[col_q] <= pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (accept) begin
			left_q <= pix;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= pix;
			prev_q   <= left_q;
			dest_q   <= idx_q;
			has_up_q <= row_q != '0;
		end
	end

	// channel distances
	always_comb begin
		nbr      = edge_up_q ? row_rd_q : prev_q;
		dr       = abs_diff(nbr[CHAN_W-1:0], cur_q[CHAN_W-1:0]);
		dg       = abs_diff(nbr[2*CHAN_W-1:CHAN_W], cur_q[2*CHAN_W-1:CHAN_W]);
		db       = abs_diff(nbr[PIX_W-1:2*CHAN_W], cur_q[PIX_W-1:2*CHAN_W]);
		sr       = dr * dr;
		sg       = dg * dg;
		sb       = db * db;
		sum      = SUM_W'(sr) + SUM_W'(sg) + SUM_W'(sb);
		radicand = {sum, {(RAD_W - SUM_W){1'b0}}};
		gray_wt  = {1'b0, dr, {FRAC_W{1'b0}}};
	end

	pgew_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		sq_start = 1'b0;
		load     = 1'b0;
		more     = !edge_up_q && has_up_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && ((col_q != '0) || (row_q != '0))) begin
					state_nx = S_CALC;
				end
			end
			S_CALC: begin
				if (mode_q == MODE_GRAY) begin
					state_nx = S_DONE;
				end else begin
					sq_start = 1'b1;
					state_nx = S_ROOT;
				end
			end
			S_ROOT: begin
				if (sq_done) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load     = 1'b1;
					state_nx = more ? S_CALC : S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edge_up_q <= col_q == '0;
		end else if (load) begin
			edge_up_q <= 1'b1;
		end
		if (state_q == S_CALC) begin
			wt_q <= gray_wt;
		end else if (state_q == S_ROOT && sq_done) begin
			wt_q <= root;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			src_out_q  <= edge_up_q ? dest_q - IDX_W'(w_eff) : dest_q - IDX_W'(1);
			dest_out_q <= dest_q;
			wt_out_q   <= wt_q;
			last_out_q <= !more;
		end
	end

	assign out_valid    = out_valid_q;
	assign source_index = src_out_q;
	assign dest_index   = dest_out_q;
	assign edge_weight  = wt_out_q;
	assign last_edge    = last_out_q;

endmodule

[tb/tb_pixel_grid_edge_weights.sv]
// testbench of pixel_grid_edge_weights: raster pixels in, predicted edge words checked
`timescale 1ns / 100ps

module tb_pixel_grid_edge_weights;
	import pgew_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int QUIET_CYCLES = 60;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_PIXELS = 900;
	localparam int WIDE_PIXELS = 40;

	typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

	typedef struct packed {
		logic [IDX_W-1:0]    src;
		logic [IDX_W-1:0]    dst;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
	} edge_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [CHAN_W-1:0]     red_or_gray = '0;
	logic [CHAN_W-1:0]     green = '0;
	logic [CHAN_W-1:0]     blue = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [IDX_W-1:0]      source_index;
	logic [IDX_W-1:0]      dest_index;
	logic [WEIGHT_W-1:0]   edge_weight;
	logic                  last_edge;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// model state
	logic [DIM_W-1:0]  cur_width = 12'd2048;
	logic [DIM_W-1:0]  cur_height = 12'd2048;
	logic              cur_mode = MODE_RGB;
	logic [PIX_W-1:0]  row_mem [MAX_WIDTH];
	logic [PIX_W-1:0]  left_pix = '0;
	int                col_pos = 0;
	int                row_pos = 0;
	edge_word_t        pending_edges [$];

	ready_mode_t       ready_mode = READY_ALWAYS;
	logic [15:0]       ready_pattern = 16'b1011_0011_1000_1101;
	int                hold_len = 0;
	int                gap_max = 0;
	int                burst_left = 0;
	int                idle_cycles = 0;
	int                fail_count = 0;
	int                pixels_sent = 0;
	int                words_checked = 0;
	int                reg_writes = 0;
	logic [PIX_W-1:0]  last_sent = '0;

	pixel_grid_edge_weights dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red_or_gray  (red_or_gray),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.source_index (source_index),
		.dest_index   (dest_index),
		.edge_weight  (edge_weight),
		.last_edge    (last_edge),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < MAX_WIDTH; i++)
			row_mem[i] = '0;
	end

	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
		if (v == 0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic logic [WEIGHT_W-1:0] color_distance(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		int d;
		int d_first;
		longint unsigned sq;
		longint unsigned root;
		longint unsigned trial;
		sq = 0;
		d_first = 0;
		for (int c = 0; c < 3; c++) begin
			d = int'(a[CHAN_W*c +: CHAN_W]) - int'(b[CHAN_W*c +: CHAN_W]);
			if (d < 0)
				d = -d;
			if (c == 0)
				d_first = d;
			sq += longint'(d * d);
		end
		if (cur_mode == MODE_GRAY)
			return WEIGHT_W'(d_first << FRAC_W);
		sq = sq << (2 * FRAC_W);
		root = 0;
		for (int i = WEIGHT_W - 1; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= sq)
				root = trial;
		end
		return root[WEIGHT_W-1:0];
	endfunction

	function automatic void predict_pixel_edges(input logic [PIX_W-1:0] pix);
		int w;
		int h;
		int x;
		int y;
		edge_word_t e;
		w = eff_dim(cur_width, MAX_WIDTH);
		h = eff_dim(cur_height, MAX_HEIGHT);
		x = col_pos;
		y = row_pos;
		if (x >= w)
			x = 0;
		if (y >= h)
			y = 0;
		e.dst = IDX_W'(x + w * y);
		if (x > 0) begin
			e.src = IDX_W'(x - 1 + w * y);
			e.weight = color_distance(left_pix, pix);
			e.last = (y == 0);
			pending_edges.push_back(e);
		end
		if (y > 0) begin
			e.src = IDX_W'(x + w * (y - 1));
			e.weight = color_distance(row_mem[x], pix);
			e.last = 1'b1;
			pending_edges.push_back(e);
		end
		row_mem[x] = pix;
		left_pix = pix;
		x++;
		if (x >= w) begin
			x = 0;
			y++;
			if (y >= h)
				y = 0;
		end
		col_pos = x;
		row_pos = y;
	endfunction

	// one pixel word; valid stays up into the next call unless a gap is taken
	task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b);
		int gap;
		in_valid <= 1'b1;
		red_or_gray <= r;
		green <= g;
		blue <= b;
		do
			@(posedge clk);
		while (!in_ready);
		predict_pixel_edges({b, g, r});
		last_sent = {b, g, r};
		pixels_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_edges.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_WIDTH: begin
				cur_width = val;
				col_pos = 0;
				row_pos = 0;
			end
			REG_HEIGHT: begin
				cur_height = val;
				col_pos = 0;
				row_pos = 0;
			end
			REG_MODE: cur_mode = val[0];
			default: ;
		endcase
		reg_writes++;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_pixel();
		if ($urandom_range(0, 7) == 0)
			send_pixel(last_sent[7:0], last_sent[15:8], last_sent[23:16]);
		else
			send_pixel(pick_level(), pick_level(), pick_level());
	endtask

	task automatic test_reset_defaults();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'hFF, 8'h00);
		settle();
	endtask

	task automatic test_small_frame_rgb();
		ready_mode = READY_PATTERN;
		write_reg(REG_WIDTH, 12'd3);
		write_reg(REG_HEIGHT, 12'd2);
		write_reg(REG_MODE, 12'd1);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h80, 8'h40, 8'h20);
		send_pixel(8'h01, 8'h02, 8'h03);
		settle();
	endtask

	task automatic test_grayscale();
		ready_mode = READY_RANDOM;
		gap_max = 3;
		write_reg(REG_MODE, 12'hFFE);
		write_reg(REG_WIDTH, 12'd2);
		write_reg(REG_HEIGHT, 12'd2);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'h11, 8'hC8);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hC8, 8'h5A, 8'hA5);
		settle();
	endtask

	// zero width and zero height act as one
	task automatic test_degenerate_sizes();
		ready_mode = READY_ALWAYS;
		gap_max = 0;
		write_reg(REG_MODE, 12'h001);
		write_reg(REG_WIDTH, 12'd0);
		write_reg(REG_HEIGHT, 12'd3);
		repeat (3) send_random_pixel();
		settle();
		write_reg(REG_WIDTH, 12'd4);
		write_reg(REG_HEIGHT, 12'd0);
		repeat (3) send_random_pixel();
		settle();
	endtask

	task automatic test_unused_register();
		write_reg(REG_WIDTH, 12'd3);
		write_reg(REG_HEIGHT, 12'd3);
		write_reg(REG_MODE, 12'hFFF);
		repeat (2) send_random_pixel();
		settle();
		write_reg(REG_UNUSED, 12'hFFF);
		repeat (2) send_random_pixel();
		settle();
	endtask

	// largest width and height settings over the start of a long row
	task automatic test_wide_rows();
		ready_mode = READY_RANDOM;
		gap_max = 2;
		write_reg(REG_MODE, 12'h000);
		write_reg(REG_WIDTH, 12'hFFF);
		write_reg(REG_HEIGHT, 12'hFFF);
		repeat (WIDE_PIXELS) send_random_pixel();
		settle();
	endtask

	task automatic test_backpressure();
		ready_mode = READY_ALWAYS;
		gap_max = 0;
		write_reg(REG_MODE, 12'h001);
		write_reg(REG_WIDTH, 12'd5);
		write_reg(REG_HEIGHT, 12'd4);
		repeat (5) send_random_pixel();
		hold_len = 400;
		repeat (40) send_random_pixel();
		settle();
	endtask

	function automatic logic [DIM_W-1:0] pick_dim(input int common_max);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return DIM_W'($urandom_range(0, 4095));
			3, 4: return DIM_W'($urandom_range(common_max + 1, 64));
			default: return DIM_W'($urandom_range(1, common_max));
		endcase
	endfunction

	task automatic test_random_frames();
		int start_count;
		int phase_len;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			// some phases only write the mode register, so the frame carries on
			if ($urandom_range(0, 9) >= 2) begin
				if ($urandom_range(0, 1)) begin
					write_reg(REG_WIDTH, pick_dim(12));
					write_reg(REG_HEIGHT, pick_dim(8));
				end else begin
					write_reg(REG_HEIGHT, pick_dim(8));
					write_reg(REG_WIDTH, pick_dim(12));
				end
				if ($urandom_range(0, 1))
					write_reg(REG_MODE, DIM_W'($urandom_range(0, 4095)));
			end else begin
				write_reg(REG_MODE, DIM_W'($urandom_range(0, 4095)));
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, DIM_W'($urandom_range(0, 4095)));
			ready_mode = ready_mode_t'($urandom_range(0, 2));
			gap_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			phase_len = $urandom_range(10, 60);
			repeat (phase_len) send_random_pixel();
			settle();
		end
	endtask

	always @(posedge clk) begin : edge_checker
		edge_word_t want;
		if (out_valid && out_ready) begin
			if (pending_edges.size() == 0) begin
				$error("unexpected edge word: source %0d dest %0d", source_index, dest_index);
				fail_count++;
			end else begin
				want = pending_edges.pop_front();
				words_checked++;
				if (source_index !== want.src) begin
					$error("source_index: expected %0d, got %0d", want.src, source_index);
					fail_count++;
				end
				if (dest_index !== want.dst) begin
					$error("dest_index: expected %0d, got %0d", want.dst, dest_index);
					fail_count++;
				end
				if (edge_weight !== want.weight) begin
					$error("edge_weight: expected %0d, got %0d", want.weight, edge_weight);
					fail_count++;
				end
				if (last_edge !== want.last) begin
					$error("last_edge: expected %0d, got %0d", want.last, last_edge);
					fail_count++;
				end
			end
		end
		if (hold_len > 0) begin
			out_ready <= 1'b0;
			hold_len--;
		end else begin
			case (ready_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
				default: begin
					out_ready <= ready_pattern[0];
					ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_small_frame_rgb();
		test_grayscale();
		test_degenerate_sizes();
		test_unused_register();
		test_wide_rows();
		test_backpressure();
		test_random_frames();
		$display("covered %0d pixels under %0d register writes, %0d edge words checked",
			pixels_sent, reg_writes, words_checked);
		$display("rgb and gray modes, sizes 0 to 4095, frame wraps, long receiver hold-off");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[pixel_grid_edge_weights.f]
design/pgew_pkg.sv
design/pgew_sqrt.sv
design/pixel_grid_edge_weights.sv
tb/tb_pixel_grid_edge_weights.sv
